// ===== rtl/ptise_pkg.sv =====
// shared constants and types for the platform-table i2c segment extractor
// no dependencies; imported by platform_table_i2c_segment_extractor
`default_nettype none

package ptise_pkg;

	// configuration and position widths
	localparam int unsigned LengthBits          = 20;
	localparam int unsigned PositionBitsDefault = 20;

	// record layout
	localparam logic [7:0]  KindEngine     = 8'd14;
	localparam logic [7:0]  KindEnd        = 8'd255;
	localparam logic [7:0]  FirstSizeUnits = 8'd7;
	localparam int unsigned UnitShift      = 4;
	localparam int unsigned HeaderBytes    = 32;
	localparam int unsigned CountOffset    = 70;
	localparam int unsigned SegmentsOffset = 80;
	localparam int unsigned SegmentBytes   = 32;
	localparam int unsigned SegShift       = 5;

	// byte positions inside one segment
	localparam logic [SegShift-1:0] SegIdByte   = 5'd5;
	localparam logic [SegShift-1:0] SegMuxByte  = 5'd16;
	localparam logic [SegShift-1:0] SegCpldByte = 5'd17;
	localparam logic [SegShift-1:0] SegMaskByte = 5'd19;

	// mux type that maps through a cpld register
	localparam logic [7:0] MuxCpld = 8'd1;

	// end of parse status codes
	typedef enum logic [1:0] {
		EndNormal    = 2'd0,
		EndLayout    = 2'd1,
		EndOverrun   = 2'd2,
		EndTruncated = 2'd3
	} end_status_t;

endpackage

`default_nettype wire

// ===== rtl/platform_table_i2c_segment_extractor.sv =====
// throughput: one blob byte per cycle; one input register feeds the parse logic, whose
// result lands in an output register; a result beat held by out_stall stalls intake
// reset: arst_n clears blob_length to 0 and the parser to offset zero; a write to
// blob_length also restarts the parser at offset zero
// depends on ptise_pkg (constants, status codes)
`default_nettype none

module platform_table_i2c_segment_extractor #(
	parameter int unsigned POSITION_BITS = ptise_pkg::PositionBitsDefault
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ptise_pkg::LengthBits-1:0] blob_length,
	// blob byte channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     data_byte,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                mapping_valid,
	output logic [7:0]                          segment_id,
	output logic [7:0]                          cpld_register,
	output logic [7:0]                          select_mask,
	output logic                                done_res,
	output logic [1:0]                          end_status
);

	import ptise_pkg::*;

	localparam int unsigned P  = POSITION_BITS;
	localparam int unsigned WB = ((P > LengthBits) ? P : LengthBits) + 1;
	localparam int unsigned RecBits = 8 + UnitShift;
	localparam int unsigned IdxBits = P - SegShift;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// parser state
	logic [LengthBits-1:0] blob_length_q;
	logic [P-1:0]          pos_q;
	logic [P-1:0]          start_q;
	logic [RecBits-1:0]    rec_bytes_q;
	logic [7:0]            kind_q;
	logic [7:0]            count_q;
	logic [7:0]            seg_id_q;
	logic [7:0]            mux_q;
	logic [7:0]            cpld_q;
	logic                  stopped_q;
	logic                  first_q;

	// output register
	logic        out_valid_q;
	logic        map_q;
	logic [7:0]  seg_out_q;
	logic [7:0]  cpld_out_q;
	logic [7:0]  mask_out_q;
	logic        done_q;
	logic [1:0]  status_q;

	// handshakes
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = !valid_s1;

	// parse datapath
	logic [P-1:0]       rel;
	logic [WB-1:0]      pos_w;
	logic [WB-1:0]      len_w;
	logic [WB-1:0]      start_w;
	logic [WB-1:0]      next_w;
	logic [P-1:0]       next_pos;
	logic [RecBits-1:0] size_bytes;
	logic               in_range;
	logic [P-1:0]       seg_k;
	logic [SegShift-1:0] seg_sub;
	logic [IdxBits-1:0] seg_idx;
	logic [P:0]         seg_end;
	logic               seg_fits;
	logic               last_byte;

	assign rel        = pos_q - start_q;
	assign pos_w      = WB'(pos_q);
	assign len_w      = WB'(blob_length_q);
	assign start_w    = WB'(start_q);
	assign next_pos   = pos_q + P'(1);
	assign next_w     = WB'(next_pos);
	assign size_bytes = {byte_s1, {UnitShift{1'b0}}};
	assign in_range   = !stopped_q && (pos_w < len_w) && (pos_q >= start_q);
	assign seg_k      = rel - P'(SegmentsOffset);
	assign seg_sub    = seg_k[SegShift-1:0];
	assign seg_idx    = seg_k[P-1:SegShift];
	assign seg_end    = {1'b0, seg_idx, {SegShift{1'b0}}}
		+ (P+1)'(SegmentsOffset + SegmentBytes);
	assign seg_fits   = (rel >= P'(SegmentsOffset))
		&& (seg_idx < IdxBits'(count_q))
		&& (seg_end <= (P+1)'(rec_bytes_q));
	assign last_byte  = ({1'b0, rel} + (P+1)'(1)) == (P+1)'(rec_bytes_q);

	// per-byte decisions
	logic        res_valid;
	logic        res_map;
	logic        res_done;
	end_status_t res_status;
	logic        upd_kind;
	logic        upd_size;
	logic        upd_count;
	logic        upd_id;
	logic        upd_mux;
	logic        upd_cpld;
	logic        upd_start;

	always_comb begin
		res_valid  = 1'b0;
		res_map    = 1'b0;
		res_done   = 1'b0;
		res_status = EndNormal;
		upd_kind   = 1'b0;
		upd_size   = 1'b0;
		upd_count  = 1'b0;
		upd_id     = 1'b0;
		upd_mux    = 1'b0;
		upd_cpld   = 1'b0;
		upd_start  = 1'b0;
		if (rel == '0) begin
			// record type byte
			upd_kind = 1'b1;
			if (start_w + WB'(HeaderBytes) > len_w) begin
				res_valid = 1'b1;
				res_done  = 1'b1;
			end
		end else if (rel == P'(1)) begin
			// record size byte
			res_valid = 1'b1;
			res_done  = 1'b1;
			if (first_q && byte_s1 != FirstSizeUnits) begin
				res_status = EndLayout;
			end else if (kind_q == KindEnd || byte_s1 == '0) begin
				res_status = EndNormal;
			end else if (start_w + WB'(size_bytes) > len_w) begin
				res_status = EndOverrun;
			end else if (kind_q == KindEngine
				&& start_w + WB'(SegmentsOffset) > len_w) begin
				res_status = EndTruncated;
			end else begin
				res_valid = 1'b0;
				res_done  = 1'b0;
				upd_size  = 1'b1;
			end
		end else begin
			// record body
			if (kind_q == KindEngine) begin
				if (rel == P'(CountOffset)) begin
					upd_count = 1'b1;
				end else if (seg_fits) begin
					case (seg_sub)
						SegIdByte:   upd_id   = 1'b1;
						SegMuxByte:  upd_mux  = 1'b1;
						SegCpldByte: upd_cpld = 1'b1;
						SegMaskByte: begin
							if (mux_q == MuxCpld) begin
								res_valid = 1'b1;
								res_map   = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			if (!res_map && last_byte) begin
				upd_start = 1'b1;
				if (next_w + WB'(HeaderBytes) > len_w) begin
					res_valid = 1'b1;
					res_done  = 1'b1;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blob_length_q <= '0;
			pos_q         <= '0;
			start_q       <= '0;
			rec_bytes_q   <= '0;
			kind_q        <= '0;
			count_q       <= '0;
			seg_id_q      <= '0;
			mux_q         <= '0;
			cpld_q        <= '0;
			stopped_q     <= 1'b0;
			first_q       <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			blob_length_q <= blob_length;
			pos_q         <= '0;
			start_q       <= '0;
			rec_bytes_q   <= '0;
			kind_q        <= '0;
			count_q       <= '0;
			seg_id_q      <= '0;
			mux_q         <= '0;
			cpld_q        <= '0;
			stopped_q     <= 1'b0;
			first_q       <= 1'b1;
		end else if (advance && in_range) begin
			pos_q <= next_pos;
			if (res_done) begin
				stopped_q <= 1'b1;
			end
			if (upd_kind) begin
				kind_q <= byte_s1;
			end
			if (upd_size) begin
				rec_bytes_q <= size_bytes;
				first_q     <= 1'b0;
			end
			if (upd_count) begin
				count_q <= byte_s1;
			end
			if (upd_id) begin
				seg_id_q <= byte_s1;
			end
			if (upd_mux) begin
				mux_q <= byte_s1;
			end
			if (upd_cpld) begin
				cpld_q <= byte_s1;
			end
			if (upd_start) begin
				start_q <= next_pos;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= advance && in_range && res_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance && in_range && res_valid) begin
			map_q      <= res_map;
			seg_out_q  <= res_map ? seg_id_q : 8'd0;
			cpld_out_q <= res_map ? cpld_q : 8'd0;
			mask_out_q <= res_map ? byte_s1 : 8'd0;
			done_q     <= res_done;
			status_q   <= res_status;
		end
	end

	assign out_valid     = out_valid_q;
	assign mapping_valid = map_q;
	assign segment_id    = seg_out_q;
	assign cpld_register = cpld_out_q;
	assign select_mask   = mask_out_q;
	assign done_res      = done_q;
	assign end_status    = status_q;

endmodule

`default_nettype wire
